>>> hw/rtl/tvh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tvh_pkg;

   // Field widths fixed by the interface.
   localparam int VIEW_W  = 2;
   localparam int PIX_W   = 7;
   localparam int COORD_W = 23;
   localparam int MASK_W  = 3;
   localparam int DIFF_W  = COORD_W + 1;

   // Defaults for the top level parameters.
   localparam int GRID_SIZE_DEF   = 128;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int WEIGHT_BITS_DEF = 10;

   // Projection view codes.
   localparam logic [VIEW_W-1:0] VIEW_XY = 2'd0;
   localparam logic [VIEW_W-1:0] VIEW_YZ = 2'd1;
   localparam logic [VIEW_W-1:0] VIEW_ZX = 2'd2;

   // Axis bits that the caller XORs into its voxel store.
   localparam logic [MASK_W-1:0] ALONG_X = 3'd1;
   localparam logic [MASK_W-1:0] ALONG_Y = 3'd2;
   localparam logic [MASK_W-1:0] ALONG_Z = 3'd4;

   // Signed width of a pixel-centre minus vertex difference.
   function automatic int pos_width(input int frac_bits);
      int wide;
      wide = (PIX_W + frac_bits > COORD_W) ? PIX_W + frac_bits : COORD_W;
      return wide + 1;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tvh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tvh_front #(
   parameter int FRAC_BITS = 16,
   parameter int PW        = 25,
   parameter int MW        = 51
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [tvh_pkg::VIEW_W-1:0]  view,
   input  logic [tvh_pkg::PIX_W-1:0]   pixel_col,
   input  logic [tvh_pkg::PIX_W-1:0]   pixel_row,
   input  logic [tvh_pkg::COORD_W-1:0] va_x,
   input  logic [tvh_pkg::COORD_W-1:0] va_y,
   input  logic [tvh_pkg::COORD_W-1:0] va_z,
   input  logic [tvh_pkg::COORD_W-1:0] vb_x,
   input  logic [tvh_pkg::COORD_W-1:0] vb_y,
   input  logic [tvh_pkg::COORD_W-1:0] vb_z,
   input  logic [tvh_pkg::COORD_W-1:0] vc_x,
   input  logic [tvh_pkg::COORD_W-1:0] vc_y,
   input  logic [tvh_pkg::COORD_W-1:0] vc_z,
   output logic                        out_valid,
   output logic [tvh_pkg::VIEW_W-1:0]  out_view,
   output logic [tvh_pkg::PIX_W-1:0]   out_col,
   output logic [tvh_pkg::PIX_W-1:0]   out_row,
   output logic [tvh_pkg::COORD_W-1:0] out_w0,
   output logic [tvh_pkg::COORD_W-1:0] out_w1,
   output logic [tvh_pkg::COORD_W-1:0] out_w2,
   output logic                        out_ok,
   output logic [MW-1:0]               out_mag1,
   output logic [MW-1:0]               out_mag2,
   output logic [MW-1:0]               out_amag
);
   import tvh_pkg::*;

   localparam int PRW = PW + DIFF_W;
   localparam int CW  = PRW + 1;
   localparam int AW  = MW + 1;

   typedef logic [COORD_W-1:0] coord_type;
   typedef struct packed {
      logic [VIEW_W-1:0] view;
      logic [PIX_W-1:0]  col;
      logic [PIX_W-1:0]  row;
      coord_type         w0;
      coord_type         w1;
      coord_type         w2;
      logic              view_ok;
   } side_type;

   coord_type vx [3];
   coord_type vy [3];
   coord_type vz [3];
   coord_type pu [3];
   coord_type pv [3];
   coord_type pw [3];
   logic [PW-1:0] cen_u;
   logic [PW-1:0] cen_v;
   logic          view_ok;

   assign vx[0] = va_x;
   assign vy[0] = va_y;
   assign vz[0] = va_z;
   assign vx[1] = vb_x;
   assign vy[1] = vb_y;
   assign vz[1] = vb_z;
   assign vx[2] = vc_x;
   assign vy[2] = vc_y;
   assign vz[2] = vc_z;

   // Swizzle the vertices so that the view plane is (u, v) and depth is w.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         unique case (view)
            VIEW_YZ: begin
               pu[k] = vy[k];
               pv[k] = vz[k];
               pw[k] = vx[k];
            end
            VIEW_ZX: begin
               pu[k] = vz[k];
               pv[k] = vx[k];
               pw[k] = vy[k];
            end
            default: begin
               pu[k] = vx[k];
               pv[k] = vy[k];
               pw[k] = vz[k];
            end
         endcase
      end
      view_ok = (view == VIEW_XY) || (view == VIEW_YZ) || (view == VIEW_ZX);
   end

   // Pixel centre in fixed point.
   assign cen_u = (PW'(pixel_col) << FRAC_BITS) | (PW'(1) << (FRAC_BITS - 1));
   assign cen_v = (PW'(pixel_row) << FRAC_BITS) | (PW'(1) << (FRAC_BITS - 1));

   // Stage 1: offsets from each edge origin and edge vectors.
   logic                     s1_v_ff;
   side_type                 s1_side_ff;
   logic signed [PW-1:0]     eu_ff [3];
   logic signed [PW-1:0]     ev_ff [3];
   logic signed [DIFF_W-1:0] du_ff [3];
   logic signed [DIFF_W-1:0] dv_ff [3];
   logic signed [PW-1:0]     eu_in [3];
   logic signed [PW-1:0]     ev_in [3];
   logic signed [DIFF_W-1:0] du_in [3];
   logic signed [DIFF_W-1:0] dv_in [3];
   side_type                 s1_side_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         eu_in[k] = $signed(cen_u) - $signed(PW'(pu[k]));
         ev_in[k] = $signed(cen_v) - $signed(PW'(pv[k]));
         du_in[k] = $signed(DIFF_W'(pu[(k + 1) % 3])) - $signed(DIFF_W'(pu[k]));
         dv_in[k] = $signed(DIFF_W'(pv[(k + 1) % 3])) - $signed(DIFF_W'(pv[k]));
      end
      s1_side_in.view    = view;
      s1_side_in.col     = pixel_col;
      s1_side_in.row     = pixel_row;
      s1_side_in.w0      = pw[0];
      s1_side_in.w1      = pw[1];
      s1_side_in.w2      = pw[2];
      s1_side_in.view_ok = view_ok;
   end

   // Stage 2: the two cross terms of each edge function.
   logic                  s2_v_ff;
   side_type              s2_side_ff;
   logic signed [PRW-1:0] m1_ff [3];
   logic signed [PRW-1:0] m2_ff [3];

   // Stage 3: edge function values.
   logic                 s3_v_ff;
   side_type             s3_side_ff;
   logic signed [CW-1:0] c_ff [3];

   // Stage 4: doubled area and the inside test.
   logic                 s4_v_ff;
   side_type             s4_side_ff;
   logic signed [CW-1:0] c1_ff;
   logic signed [CW-1:0] c2_ff;
   logic signed [AW-1:0] area_ff;
   logic                 inside_ff;
   logic signed [AW-1:0] area_in;
   logic                 inside_in;

   always_comb begin
      area_in = AW'(c_ff[0]) + AW'(c_ff[1]) + AW'(c_ff[2]);
      inside_in = ((c_ff[0] <= 0) && (c_ff[1] <= 0) && (c_ff[2] <= 0)) ||
                  ((c_ff[0] >= 0) && (c_ff[1] >= 0) && (c_ff[2] >= 0));
   end

   // Stage 5: magnitudes for the weight divisions.
   logic                 s5_v_ff;
   side_type             s5_side_ff;
   logic [MW-1:0]        mag1_ff;
   logic [MW-1:0]        mag2_ff;
   logic [MW-1:0]        amag_ff;
   logic                 ok_ff;
   logic signed [AW-1:0] c1_ext;
   logic signed [AW-1:0] c2_ext;
   logic [MW-1:0]        mag1_in;
   logic [MW-1:0]        mag2_in;
   logic [MW-1:0]        amag_in;

   always_comb begin
      c1_ext  = AW'(c1_ff);
      c2_ext  = AW'(c2_ff);
      mag1_in = (c1_ext < 0) ? MW'(-c1_ext) : MW'(c1_ext);
      mag2_in = (c2_ext < 0) ? MW'(-c2_ext) : MW'(c2_ext);
      amag_in = (area_ff < 0) ? MW'(-area_ff) : MW'(area_ff);
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s1_side_in;
         for (int k = 0; k < 3; k++) begin
            eu_ff[k] <= eu_in[k];
            ev_ff[k] <= ev_in[k];
            du_ff[k] <= du_in[k];
            dv_ff[k] <= dv_in[k];
         end
         s2_side_ff <= s1_side_ff;
         for (int k = 0; k < 3; k++) begin
            m1_ff[k] <= PRW'(eu_ff[k]) * PRW'(dv_ff[k]);
            m2_ff[k] <= PRW'(ev_ff[k]) * PRW'(du_ff[k]);
         end
         s3_side_ff <= s2_side_ff;
         for (int k = 0; k < 3; k++) begin
            c_ff[k] <= CW'(m1_ff[k]) - CW'(m2_ff[k]);
         end
         s4_side_ff <= s3_side_ff;
         c1_ff      <= c_ff[1];
         c2_ff      <= c_ff[2];
         area_ff    <= area_in;
         inside_ff  <= inside_in;
         s5_side_ff <= s4_side_ff;
         mag1_ff    <= mag1_in;
         mag2_ff    <= mag2_in;
         amag_ff    <= amag_in;
         ok_ff      <= inside_ff && (area_ff != 0) && s4_side_ff.view_ok;
      end
   end

   assign out_valid = s5_v_ff;
   assign out_view  = s5_side_ff.view;
   assign out_col   = s5_side_ff.col;
   assign out_row   = s5_side_ff.row;
   assign out_w0    = s5_side_ff.w0;
   assign out_w1    = s5_side_ff.w1;
   assign out_w2    = s5_side_ff.w2;
   assign out_ok    = ok_ff;
   assign out_mag1  = mag1_ff;
   assign out_mag2  = mag2_ff;
   assign out_amag  = amag_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tvh_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module tvh_divider #(
   parameter int MW = 51,
   parameter int QW = 10,
   parameter int SW = 86
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [MW-1:0] num0,
   input  logic [MW-1:0] num1,
   input  logic [MW-1:0] den,
   input  logic [SW-1:0] side,
   output logic          out_valid,
   output logic [QW:0]   quo0,
   output logic [QW:0]   quo1,
   output logic [SW-1:0] side_out
);

   // One restoring step per stage: stage 0 loads, stages 1..QW make one bit each.
   logic          v_ff     [QW+1];
   logic [MW-1:0] r0_ff    [QW+1];
   logic [MW-1:0] r1_ff    [QW+1];
   logic [QW-1:0] q0_ff    [QW+1];
   logic [QW-1:0] q1_ff    [QW+1];
   logic          full0_ff [QW+1];
   logic          full1_ff [QW+1];
   logic [MW-1:0] den_ff   [QW+1];
   logic [SW-1:0] side_ff  [QW+1];

   // Stage 0 registers the operands and flags a full-scale quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff[0]    <= num0;
         r1_ff[0]    <= num1;
         q0_ff[0]    <= '0;
         q1_ff[0]    <= '0;
         full0_ff[0] <= (num0 >= den);
         full1_ff[0] <= (num1 >= den);
         den_ff[0]   <= den;
         side_ff[0]  <= side;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [MW:0]   sh0;
      logic [MW:0]   sh1;
      logic          ge0;
      logic          ge1;
      logic [MW-1:0] r0_in;
      logic [MW-1:0] r1_in;

      // Shift the remainder and subtract the divisor when it fits.
      always_comb begin
         sh0   = {r0_ff[k-1], 1'b0};
         sh1   = {r1_ff[k-1], 1'b0};
         ge0   = (sh0 >= {1'b0, den_ff[k-1]});
         ge1   = (sh1 >= {1'b0, den_ff[k-1]});
         r0_in = ge0 ? MW'(sh0 - {1'b0, den_ff[k-1]}) : MW'(sh0);
         r1_in = ge1 ? MW'(sh1 - {1'b0, den_ff[k-1]}) : MW'(sh1);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r0_ff[k]    <= r0_in;
            r1_ff[k]    <= r1_in;
            q0_ff[k]    <= {q0_ff[k-1][QW-2:0], ge0};
            q1_ff[k]    <= {q1_ff[k-1][QW-2:0], ge1};
            full0_ff[k] <= full0_ff[k-1];
            full1_ff[k] <= full1_ff[k-1];
            den_ff[k]   <= den_ff[k-1];
            side_ff[k]  <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign quo0      = full0_ff[QW] ? ((QW+1)'(1) << QW) : {1'b0, q0_ff[QW]};
   assign quo1      = full1_ff[QW] ? ((QW+1)'(1) << QW) : {1'b0, q1_ff[QW]};
   assign side_out  = side_ff[QW];

endmodule

`default_nettype wire

>>> hw/rtl/tvh_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module tvh_blend #(
   parameter int GRID_SIZE   = 128,
   parameter int FRAC_BITS   = 16,
   parameter int WEIGHT_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [WEIGHT_BITS:0]        b0,
   input  logic [WEIGHT_BITS:0]        b1,
   input  logic                        ok,
   input  logic [tvh_pkg::VIEW_W-1:0]  view,
   input  logic [tvh_pkg::PIX_W-1:0]   col,
   input  logic [tvh_pkg::PIX_W-1:0]   row,
   input  logic [tvh_pkg::COORD_W-1:0] w0,
   input  logic [tvh_pkg::COORD_W-1:0] w1,
   input  logic [tvh_pkg::COORD_W-1:0] w2,
   output logic                        out_valid,
   output logic                        out_hit,
   output logic [tvh_pkg::COORD_W-1:0] out_depth,
   output logic [tvh_pkg::PIX_W-1:0]   out_vx,
   output logic [tvh_pkg::PIX_W-1:0]   out_vy,
   output logic [tvh_pkg::PIX_W-1:0]   out_vz,
   output logic [tvh_pkg::MASK_W-1:0]  out_mask
);
   import tvh_pkg::*;

   localparam int BW  = WEIGHT_BITS + 1;
   localparam int PRW = WEIGHT_BITS + COORD_W + 1;
   localparam int SMW = PRW + 2;
   localparam logic [BW:0] ONE = (BW + 1)'(1) << WEIGHT_BITS;

   function automatic logic [PIX_W-1:0] sat_grid(input logic [31:0] v);
      logic [31:0] top;
      top = 32'(GRID_SIZE - 1);
      return (v > top) ? PIX_W'(top) : PIX_W'(v);
   endfunction

   // Third weight, clamped at zero.
   logic [BW:0]   sum01;
   logic [BW-1:0] b2;

   always_comb begin
      sum01 = (BW + 1)'(b0) + (BW + 1)'(b1);
      b2    = (sum01 > ONE) ? '0 : BW'(ONE - sum01);
   end

   // Stage 1: weighted depth terms.
   logic              s1_v_ff;
   logic [PRW-1:0]    t0_ff;
   logic [PRW-1:0]    t1_ff;
   logic [PRW-1:0]    t2_ff;
   logic              ok_ff;
   logic [VIEW_W-1:0] view_ff;
   logic [PIX_W-1:0]  col_ff;
   logic [PIX_W-1:0]  row_ff;

   // Stage 2: depth sum, voxel index and the output register.
   logic [SMW-1:0]     sum;
   logic [COORD_W-1:0] depth;
   logic [PIX_W-1:0]   dz;
   logic [PIX_W-1:0]   sc;
   logic [PIX_W-1:0]   sr;
   logic               hit_in;
   logic [PIX_W-1:0]   vx_in;
   logic [PIX_W-1:0]   vy_in;
   logic [PIX_W-1:0]   vz_in;
   logic [MASK_W-1:0]  mask_in;

   always_comb begin
      sum    = SMW'(t0_ff) + SMW'(t1_ff) + SMW'(t2_ff);
      depth  = COORD_W'(sum >> WEIGHT_BITS);
      dz     = sat_grid(32'(depth >> FRAC_BITS));
      sc     = sat_grid(32'(col_ff));
      sr     = sat_grid(32'(row_ff));
      hit_in = ok_ff;
      unique case (view_ff)
         VIEW_YZ: begin
            vx_in   = dz;
            vy_in   = sc;
            vz_in   = sr;
            mask_in = ALONG_X;
         end
         VIEW_ZX: begin
            vx_in   = sr;
            vy_in   = dz;
            vz_in   = sc;
            mask_in = ALONG_Y;
         end
         default: begin
            vx_in   = sc;
            vy_in   = sr;
            vz_in   = dz;
            mask_in = ALONG_Z;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         out_valid <= 1'b0;
      end else if (en) begin
         s1_v_ff   <= in_valid;
         out_valid <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff     <= PRW'(b0) * PRW'(w0);
         t1_ff     <= PRW'(b1) * PRW'(w1);
         t2_ff     <= PRW'(b2) * PRW'(w2);
         ok_ff     <= ok;
         view_ff   <= view;
         col_ff    <= col;
         row_ff    <= row;
         out_hit   <= hit_in;
         out_depth <= hit_in ? depth : '0;
         out_vx    <= hit_in ? vx_in : '0;
         out_vy    <= hit_in ? vy_in : '0;
         out_vz    <= hit_in ? vz_in : '0;
         out_mask  <= hit_in ? mask_in : '0;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/triangle_voxel_hit_test_unit.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    view, pixel column/row, vertices A, B, C
// rsp       out        rsp_valid/stall    hit, depth, voxel x/y/z, axis mask
//
// One query enters per cycle while req_stall is low.
// The pipeline length is set by the bit-per-stage weight divider: five setup stages,
// WEIGHT_BITS + 1 divider stages and two blend stages.
// Reset clears only the valid bits of the stages; data registers are not reset.
// A stall on rsp while a result waits freezes the whole pipeline and raises req_stall.
`timescale 1ns / 1ps
`default_nettype none

module triangle_voxel_hit_test_unit #(
   parameter int GRID_SIZE   = tvh_pkg::GRID_SIZE_DEF,
   parameter int FRAC_BITS   = tvh_pkg::FRAC_BITS_DEF,
   parameter int WEIGHT_BITS = tvh_pkg::WEIGHT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tvh_pkg::VIEW_W-1:0]  req_view,
   input  logic [tvh_pkg::PIX_W-1:0]   req_pixel_col,
   input  logic [tvh_pkg::PIX_W-1:0]   req_pixel_row,
   input  logic [tvh_pkg::COORD_W-1:0] req_va_x,
   input  logic [tvh_pkg::COORD_W-1:0] req_va_y,
   input  logic [tvh_pkg::COORD_W-1:0] req_va_z,
   input  logic [tvh_pkg::COORD_W-1:0] req_vb_x,
   input  logic [tvh_pkg::COORD_W-1:0] req_vb_y,
   input  logic [tvh_pkg::COORD_W-1:0] req_vb_z,
   input  logic [tvh_pkg::COORD_W-1:0] req_vc_x,
   input  logic [tvh_pkg::COORD_W-1:0] req_vc_y,
   input  logic [tvh_pkg::COORD_W-1:0] req_vc_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic [tvh_pkg::COORD_W-1:0] rsp_depth_fixed,
   output logic [tvh_pkg::PIX_W-1:0]   rsp_voxel_x,
   output logic [tvh_pkg::PIX_W-1:0]   rsp_voxel_y,
   output logic [tvh_pkg::PIX_W-1:0]   rsp_voxel_z,
   output logic [tvh_pkg::MASK_W-1:0]  rsp_axis_mask
);
   import tvh_pkg::*;

   localparam int PW = pos_width(FRAC_BITS);
   localparam int MW = PW + DIFF_W + 2;

   typedef struct packed {
      logic              ok;
      logic [VIEW_W-1:0] view;
      logic [PIX_W-1:0]  col;
      logic [PIX_W-1:0]  row;
      logic [COORD_W-1:0] w0;
      logic [COORD_W-1:0] w1;
      logic [COORD_W-1:0] w2;
   } carry_type;

   localparam int SW = $bits(carry_type);

   // The pipeline advances unless a finished result is held back.
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   logic            fr_valid;
   logic            fr_ok;
   logic [MW-1:0]   fr_mag1;
   logic [MW-1:0]   fr_mag2;
   logic [MW-1:0]   fr_amag;
   carry_type       fr_carry;
   carry_type       dv_carry;
   logic [SW-1:0]   dv_side;
   logic            dv_valid;
   logic [WEIGHT_BITS:0] dv_q0;
   logic [WEIGHT_BITS:0] dv_q1;

   tvh_front #(
      .FRAC_BITS (FRAC_BITS),
      .PW        (PW),
      .MW        (MW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .view      (req_view),
      .pixel_col (req_pixel_col),
      .pixel_row (req_pixel_row),
      .va_x      (req_va_x),
      .va_y      (req_va_y),
      .va_z      (req_va_z),
      .vb_x      (req_vb_x),
      .vb_y      (req_vb_y),
      .vb_z      (req_vb_z),
      .vc_x      (req_vc_x),
      .vc_y      (req_vc_y),
      .vc_z      (req_vc_z),
      .out_valid (fr_valid),
      .out_view  (fr_carry.view),
      .out_col   (fr_carry.col),
      .out_row   (fr_carry.row),
      .out_w0    (fr_carry.w0),
      .out_w1    (fr_carry.w1),
      .out_w2    (fr_carry.w2),
      .out_ok    (fr_ok),
      .out_mag1  (fr_mag1),
      .out_mag2  (fr_mag2),
      .out_amag  (fr_amag)
   );

   assign fr_carry.ok = fr_ok;

   tvh_divider #(
      .MW (MW),
      .QW (WEIGHT_BITS),
      .SW (SW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .num0      (fr_mag1),
      .num1      (fr_mag2),
      .den       (fr_amag),
      .side      (fr_carry),
      .out_valid (dv_valid),
      .quo0      (dv_q0),
      .quo1      (dv_q1),
      .side_out  (dv_side)
   );

   assign dv_carry = dv_side;

   tvh_blend #(
      .GRID_SIZE   (GRID_SIZE),
      .FRAC_BITS   (FRAC_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .b0        (dv_q0),
      .b1        (dv_q1),
      .ok        (dv_carry.ok),
      .view      (dv_carry.view),
      .col       (dv_carry.col),
      .row       (dv_carry.row),
      .w0        (dv_carry.w0),
      .w1        (dv_carry.w1),
      .w2        (dv_carry.w2),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_depth (rsp_depth_fixed),
      .out_vx    (rsp_voxel_x),
      .out_vy    (rsp_voxel_y),
      .out_vz    (rsp_voxel_z),
      .out_mask  (rsp_axis_mask)
   );

   // A hit carries exactly one axis bit.
   a_hit_mask : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> $onehot(rsp_axis_mask))
      else $error("hit result without a single axis bit");

   // A miss carries no depth and no axis bit.
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_depth_fixed == '0) && (rsp_axis_mask == '0))
      else $error("miss result with nonzero fields");

   // No result appears right after reset.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A held result keeps the input side stalled.
   a_hold_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while a result is held");

endmodule

`default_nettype wire

>>> tb/tvh_checker.sv
`timescale 1ns / 1ps

module tvh_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [tvh_pkg::VIEW_W-1:0]  req_view,
   input  logic [tvh_pkg::PIX_W-1:0]   req_pixel_col,
   input  logic [tvh_pkg::PIX_W-1:0]   req_pixel_row,
   input  logic [tvh_pkg::COORD_W-1:0] req_va_x,
   input  logic [tvh_pkg::COORD_W-1:0] req_va_y,
   input  logic [tvh_pkg::COORD_W-1:0] req_va_z,
   input  logic [tvh_pkg::COORD_W-1:0] req_vb_x,
   input  logic [tvh_pkg::COORD_W-1:0] req_vb_y,
   input  logic [tvh_pkg::COORD_W-1:0] req_vb_z,
   input  logic [tvh_pkg::COORD_W-1:0] req_vc_x,
   input  logic [tvh_pkg::COORD_W-1:0] req_vc_y,
   input  logic [tvh_pkg::COORD_W-1:0] req_vc_z,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_hit,
   input  logic [tvh_pkg::COORD_W-1:0] rsp_depth_fixed,
   input  logic [tvh_pkg::PIX_W-1:0]   rsp_voxel_x,
   input  logic [tvh_pkg::PIX_W-1:0]   rsp_voxel_y,
   input  logic [tvh_pkg::PIX_W-1:0]   rsp_voxel_z,
   input  logic [tvh_pkg::MASK_W-1:0]  rsp_axis_mask,
   output int                          fail_count,
   output int                          pending_count,
   output int                          hit_count
);
   import tvh_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int WBITS = WEIGHT_BITS_DEF;
   localparam int GMAX = GRID_SIZE_DEF - 1;

   typedef struct packed {
      logic                hit;
      logic [COORD_W-1:0]  depth;
      logic [PIX_W-1:0]    vx;
      logic [PIX_W-1:0]    vy;
      logic [PIX_W-1:0]    vz;
      logic [MASK_W-1:0]   mask;
   } voxel_hit_t;

   // Expected results in order, indexed by a running write and read count.
   voxel_hit_t expected_hits [int];
   int wr_idx = 0;
   int rd_idx = 0;

   function automatic longint clamp_grid(input longint v);
      return (v > GMAX) ? GMAX : v;
   endfunction

   // Restoring division giving floor(num * 2^WBITS / den), capped at 2^WBITS when num >= den.
   function automatic longint bary_weight(input longint num, input longint den);
      longint q, r;
      q = 0;
      r = num;
      if (num >= den) return longint'(1) << WBITS;
      for (int k = 0; k < WBITS; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function automatic voxel_hit_t predict_hit(input logic [VIEW_W-1:0] view,
         input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
         input logic [COORD_W-1:0] vert [9]);
      voxel_hit_t res;
      longint u[3], v[3], w[3];
      longint e0u, e0v, e1u, e1v, e2u, e2v, pu, pv, c0, c1, c2, area, am;
      longint b0, b1, b2, depth, dz, vxl, vyl, vzl;
      logic [MASK_W-1:0] mask;
      int ui, vi, wi;
      res = '0;
      case (view)
         VIEW_XY: begin ui = 0; vi = 1; wi = 2; mask = ALONG_Z; end
         VIEW_YZ: begin ui = 1; vi = 2; wi = 0; mask = ALONG_X; end
         VIEW_ZX: begin ui = 2; vi = 0; wi = 1; mask = ALONG_Y; end
         default: return res;
      endcase
      for (int k = 0; k < 3; k++) begin
         u[k] = vert[3*k+ui];
         v[k] = vert[3*k+vi];
         w[k] = vert[3*k+wi];
      end
      e0u = u[1] - u[0]; e0v = v[1] - v[0];
      e1u = u[2] - u[1]; e1v = v[2] - v[1];
      e2u = u[0] - u[2]; e2v = v[0] - v[2];
      // Degenerate triangles never hit.
      if ((e0u == 0 && e0v == 0) || (e1u == 0 && e1v == 0) || (e2u == 0 && e2v == 0))
         return res;
      if (e2u * e0v - e2v * e0u == 0) return res;
      pu = (longint'(col) << FRAC) + (longint'(1) << (FRAC - 1));
      pv = (longint'(row) << FRAC) + (longint'(1) << (FRAC - 1));
      c0 = (pu - u[0]) * e0v - (pv - v[0]) * e0u;
      c1 = (pu - u[1]) * e1v - (pv - v[1]) * e1u;
      c2 = (pu - u[2]) * e2v - (pv - v[2]) * e2u;
      // Points on an edge count as inside.
      if (!((c0 <= 0 && c1 <= 0 && c2 <= 0) || (c0 >= 0 && c1 >= 0 && c2 >= 0)))
         return res;
      area = c0 + c1 + c2;
      am = (area < 0) ? -area : area;
      if (am == 0) return res;
      b0 = bary_weight((c1 < 0) ? -c1 : c1, am);
      b1 = bary_weight((c2 < 0) ? -c2 : c2, am);
      b2 = (longint'(1) << WBITS) - b0 - b1;
      if (b0 + b1 > (longint'(1) << WBITS)) b2 = 0;
      depth = ((b0 * w[0] + b1 * w[1] + b2 * w[2]) >> WBITS) & 64'h7FFFFF;
      dz = clamp_grid(depth >> FRAC);
      case (view)
         VIEW_XY: begin vxl = clamp_grid(col); vyl = clamp_grid(row); vzl = dz; end
         VIEW_YZ: begin vxl = dz; vyl = clamp_grid(col); vzl = clamp_grid(row); end
         default: begin vxl = clamp_grid(row); vyl = dz; vzl = clamp_grid(col); end
      endcase
      res.hit = 1'b1;
      res.depth = depth[COORD_W-1:0];
      res.vx = vxl[PIX_W-1:0];
      res.vy = vyl[PIX_W-1:0];
      res.vz = vzl[PIX_W-1:0];
      res.mask = mask;
      return res;
   endfunction

   assign pending_count = wr_idx - rd_idx;

   // Predict on each request transfer and compare on each response transfer.
   always @(posedge clock) begin
      logic [COORD_W-1:0] verts [9];
      voxel_hit_t want;
      if (reset) begin
         fail_count <= 0;
         hit_count <= 0;
         expected_hits.delete();
         wr_idx = 0;
         rd_idx = 0;
      end else begin
         if (req_valid && !req_stall) begin
            verts = '{req_va_x, req_va_y, req_va_z, req_vb_x, req_vb_y, req_vb_z,
                      req_vc_x, req_vc_y, req_vc_z};
            expected_hits[wr_idx] = predict_hit(req_view, req_pixel_col,
                                                req_pixel_row, verts);
            wr_idx++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (wr_idx == rd_idx) begin
               $error("response transfer with no query outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_hits[rd_idx];
               expected_hits.delete(rd_idx);
               rd_idx++;
               if (want.hit) hit_count <= hit_count + 1;
               if (rsp_hit !== want.hit || rsp_depth_fixed !== want.depth ||
                   rsp_voxel_x !== want.vx || rsp_voxel_y !== want.vy ||
                   rsp_voxel_z !== want.vz || rsp_axis_mask !== want.mask)
                  fail_count <= fail_count + 1;
               if (rsp_hit !== want.hit)
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
               if (rsp_depth_fixed !== want.depth)
                  $error("depth_fixed: expected %0h, got %0h", want.depth, rsp_depth_fixed);
               if (rsp_voxel_x !== want.vx)
                  $error("voxel_x: expected %0d, got %0d", want.vx, rsp_voxel_x);
               if (rsp_voxel_y !== want.vy)
                  $error("voxel_y: expected %0d, got %0d", want.vy, rsp_voxel_y);
               if (rsp_voxel_z !== want.vz)
                  $error("voxel_z: expected %0d, got %0d", want.vz, rsp_voxel_z);
               if (rsp_axis_mask !== want.mask)
                  $error("axis_mask: expected %0d, got %0d", want.mask, rsp_axis_mask);
            end
         end
      end
   end

endmodule

>>> tb/tb_triangle_voxel_hit_test_unit.sv
`timescale 1ns / 1ps

module tb_triangle_voxel_hit_test_unit;
   import tvh_pkg::*;

   localparam int RANDOM_QUERIES = 1430;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [VIEW_W-1:0] req_view = '0;
   logic [PIX_W-1:0] req_pixel_col = '0, req_pixel_row = '0;
   logic [COORD_W-1:0] req_va_x = '0, req_va_y = '0, req_va_z = '0;
   logic [COORD_W-1:0] req_vb_x = '0, req_vb_y = '0, req_vb_z = '0;
   logic [COORD_W-1:0] req_vc_x = '0, req_vc_y = '0, req_vc_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [COORD_W-1:0] rsp_depth_fixed;
   logic [PIX_W-1:0] rsp_voxel_x, rsp_voxel_y, rsp_voxel_z;
   logic [MASK_W-1:0] rsp_axis_mask;
   int fail_count, pending_count, hit_count;
   int idle_cycles = 0;
   int query_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   triangle_voxel_hit_test_unit dut (.*);

   tvh_checker checker_i (.*);

   // Receiver stalls in runs, with quiet stretches between.
   always @(posedge clock) begin
      if ($urandom_range(0, 99) < 8) rsp_stall <= ~rsp_stall;
      else if (rsp_stall && $urandom_range(0, 3) == 0) rsp_stall <= 1'b0;
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_triangle_voxel_hit_test_unit failed");
         $finish;
      end
   end

   // Present one query and hold it until the transfer happens.
   task automatic send_query(input logic [VIEW_W-1:0] view, input logic [PIX_W-1:0] col,
         input logic [PIX_W-1:0] row, input logic [COORD_W-1:0] c [9]);
      req_valid <= 1'b1;
      req_view <= view;
      req_pixel_col <= col;
      req_pixel_row <= row;
      {req_va_x, req_va_y, req_va_z} <= {c[0], c[1], c[2]};
      {req_vb_x, req_vb_y, req_vb_z} <= {c[3], c[4], c[5]};
      {req_vc_x, req_vc_y, req_vc_z} <= {c[6], c[7], c[8]};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      query_count++;
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Plane coordinate near the pixel grid so that many queries hit.
   function automatic logic [COORD_W-1:0] near_coord(input int centre);
      int v;
      v = centre + $urandom_range(0, 24 << 16) - (12 << 16);
      if (v < 0) v = 0;
      if (v > 23'h7FFFFF) v = 23'h7FFFFF;
      return v[COORD_W-1:0];
   endfunction

   initial begin
      logic [COORD_W-1:0] c [9];
      logic [VIEW_W-1:0] view;
      logic [PIX_W-1:0] col, row;
      int centre_u, centre_v, mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: one triangle in all four view codes, then the two corner pixels in XY.
      c = '{23'h000000, 23'h000000, 23'h050000, 23'h140000, 23'h000000, 23'h0A0000,
            23'h000000, 23'h140000, 23'h7FFFFF};
      for (int vw = 0; vw < 4; vw++) send_query(vw[VIEW_W-1:0], 7'd2, 7'd3, c);
      send_query(VIEW_XY, 7'd0, 7'd0, c);
      send_query(VIEW_XY, 7'd127, 7'd127, c);
      // Pixel centre on the hypotenuse of a right triangle.
      c = '{23'h000000, 23'h000000, 23'h010000, 23'h010000, 23'h000000, 23'h020000,
            23'h000000, 23'h010000, 23'h030000};
      send_query(VIEW_XY, 7'd0, 7'd0, c);
      // Repeated vertex, then collinear vertices: both degenerate.
      c = '{23'h010000, 23'h010000, 23'h0, 23'h010000, 23'h010000, 23'h5,
            23'h300000, 23'h100000, 23'h0};
      send_query(VIEW_XY, 7'd1, 7'd1, c);
      c = '{23'h000000, 23'h000000, 23'h0, 23'h100000, 23'h100000, 23'h0,
            23'h200000, 23'h200000, 23'h0};
      send_query(VIEW_XY, 7'd5, 7'd5, c);
      // Extreme coordinates and full depth with saturation.
      c = '{23'h0, 23'h0, 23'h7FFFFF, 23'h7FFFFF, 23'h0, 23'h7FFFFF,
            23'h0, 23'h7FFFFF, 23'h7FFFFF};
      for (int vw = 0; vw < 3; vw++) begin
         send_query(vw[VIEW_W-1:0], 7'd0, 7'd0, c);
         send_query(vw[VIEW_W-1:0], 7'd127, 7'd0, c);
         send_query(vw[VIEW_W-1:0], 7'd63, 7'd64, c);
      end
      c = '{default: 23'h7FFFFF};
      send_query(VIEW_ZX, 7'd127, 7'd127, c);
      c = '{default: 23'h555555};
      send_query(VIEW_YZ, 7'h55, 7'h2A, c);

      // Hold off until every outstanding response has come back.
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);

      // Random bursts: mostly triangles around the pixel, some with a repeated vertex, some wide noise.
      while (query_count < RANDOM_QUERIES + 20) begin
         for (int b = $urandom_range(1, 40); b > 0; b--) begin
            view = ($urandom_range(0, 19) == 0) ? 2'd3 : VIEW_W'($urandom_range(0, 2));
            col = PIX_W'($urandom);
            row = PIX_W'($urandom);
            mode = $urandom_range(0, 9);
            centre_u = (int'(col) << 16) + 32768;
            centre_v = (int'(row) << 16) + 32768;
            for (int k = 0; k < 9; k++) c[k] = COORD_W'($urandom);
            if (mode < 8) begin
               for (int k = 0; k < 3; k++) begin
                  // Place the view plane coordinates around the pixel centre.
                  case (view)
                     VIEW_YZ: begin c[3*k+1] = near_coord(centre_u);
                        c[3*k+2] = near_coord(centre_v); end
                     VIEW_ZX: begin c[3*k+2] = near_coord(centre_u);
                        c[3*k] = near_coord(centre_v); end
                     default: begin c[3*k] = near_coord(centre_u);
                        c[3*k+1] = near_coord(centre_v); end
                  endcase
               end
            end else if (mode == 8) begin
               c[6] = c[0];
               c[7] = c[1];
               c[8] = c[2];
            end
            send_query(view, col, row, c);
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
         if ($urandom_range(0, 60) == 0) begin
            req_valid <= 1'b0;
            while (pending_count != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d pixel queries over all views, with degenerate and", query_count);
      $display("edge cases; %0d of them hit.", hit_count);
      if (fail_count == 0)
         $display("tb_triangle_voxel_hit_test_unit passed");
      else
         $display("tb_triangle_voxel_hit_test_unit failed");
      $finish;
   end

endmodule
